/* src/clbp_pkg.sv */
package clbp_pkg;

  // Item command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT     = 2'd2;

  // Field and register widths
  localparam int unsigned LINE_COUNT_W = 17;
  localparam int unsigned LB_LOG2_W    = 3;
  localparam int unsigned PROBE_W      = 8;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HASH_W       = 32;

  // Byte index before truncation: line index shifted by up to 6
  localparam int unsigned IDX_W = LINE_COUNT_W + 6;

  localparam logic [LB_LOG2_W-1:0] LB_LOG2_MAX   = 3'd6;
  localparam logic [LB_LOG2_W-1:0] LB_LOG2_RESET = 3'd6;
  localparam logic [PROBE_W-1:0]   PROBE_RESET   = 8'd6;

  localparam int unsigned MEM_BYTES_DEFAULT = 65536;

endpackage

/* src/clbp_ram.sv */
module clbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cache_local_bloom_probe_unit.sv */
// Channel   Signals                                        Transfer when
// --------  ---------------------------------------------  ------------------------
// item in   cmd, byte_addr, byte_value, hash               start && !busy
// result    may_match, config_error                        done (one cycle)
// config    cfg_we, cfg_index, cfg_wdata                   cfg_we
//
// Byte write: written to the filter memory at the transfer edge, the block
//   stays free. No result.
// Query on an empty or oversized filter: result in the next cycle, block stays free.
// Other queries: bit-serial remainder (hash mod line_count) in S_DIV, then S_RD
//   and S_CHK for each probe on the single memory read port; the walk stops early
//   at the first clear bit.
// Reset (rst, synchronous) clears control and config; filter memory is not cleared.
// The receiver cannot stall: done is a one-cycle strobe.
module cache_local_bloom_probe_unit #(
  parameter int unsigned MEM_BYTES = clbp_pkg::MEM_BYTES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [clbp_pkg::ADDR_W-1:0]         byte_addr,
  input  logic [clbp_pkg::BYTE_W-1:0]         byte_value,
  input  logic [clbp_pkg::HASH_W-1:0]         hash,
  // result channel
  output logic                                done,
  output logic                                may_match,
  output logic                                config_error,
  // config port
  input  logic                                cfg_we,
  input  logic [clbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import clbp_pkg::*;

  localparam int unsigned AW    = $clog2(MEM_BYTES);
  localparam int unsigned CMP_W = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(HASH_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,    // one remainder bit per cycle
    S_RD,     // issue filter byte read
    S_CHK     // test the probed bit
  } state_t;

  // Configuration registers
  logic [LINE_COUNT_W-1:0] line_count;
  logic [LB_LOG2_W-1:0]    line_bytes_log2;
  logic [PROBE_W-1:0]      probe_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count      <= '0;
      line_bytes_log2 <= LB_LOG2_RESET;
      probe_count     <= PROBE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_COUNT:      line_count      <= cfg_wdata;
        REG_LINE_BYTES_LOG2: line_bytes_log2 <= cfg_wdata[LB_LOG2_W-1:0];
        REG_PROBE_COUNT:     probe_count     <= cfg_wdata[PROBE_W-1:0];
        default: ;           // unknown index ignored
      endcase
    end
  end

  // Transfer decode
  logic accept;
  logic wr_accept;
  logic q_accept;
  logic addr_in_range;

  assign accept        = start && !busy;
  assign addr_in_range = {{(CMP_W-ADDR_W){1'b0}}, byte_addr} < CMP_W'(MEM_BYTES);
  assign wr_accept     = accept && (cmd == CMD_WRITE) && addr_in_range;
  assign q_accept      = accept && (cmd == CMD_QUERY);

  // Filter geometry check at query time
  logic [LB_LOG2_W-1:0] lb_sat;
  logic [CMP_W-1:0]     total;
  logic                 empty_filter;
  logic                 oversized;

  assign lb_sat       = (line_bytes_log2 > LB_LOG2_MAX) ? LB_LOG2_MAX : line_bytes_log2;
  assign total        = CMP_W'(line_count) << lb_sat;
  assign empty_filter = (line_count == '0);
  assign oversized    = total > CMP_W'(MEM_BYTES);

  // Sequencer state
  state_t                  state;
  logic [HASH_W-1:0]       h;        // running probe hash
  logic [HASH_W-1:0]       delta;    // hash rotated left by 15
  logic [HASH_W-1:0]       div_sh;   // dividend, shifted out MSB first
  logic [LINE_COUNT_W-1:0] rem;      // line index once division ends
  logic [CNT_W-1:0]        div_cnt;
  logic [PROBE_W-1:0]      probe_idx;
  logic [LB_LOG2_W-1:0]    lb;

  // Remainder step for the bit-serial division
  logic [LINE_COUNT_W:0] rem_sh;
  logic                  rem_ge;

  assign rem_sh = {rem, div_sh[HASH_W-1]};
  assign rem_ge = rem_sh >= {1'b0, line_count};

  // Probe address: line base plus byte offset inside the line
  logic [IDX_W-1:0] line_base;
  logic [IDX_W-1:0] line_mask;
  logic [IDX_W-1:0] byte_off;
  logic [IDX_W-1:0] byte_idx;
  logic [AW-1:0]    raddr;
  logic [BYTE_W-1:0] rdata;
  logic             bit_set;

  assign line_base = IDX_W'(rem) << lb;
  assign line_mask = ~({IDX_W{1'b1}} << lb);
  assign byte_off  = IDX_W'(h[HASH_W-1:3]) & line_mask;
  assign byte_idx  = line_base + byte_off;
  assign raddr     = byte_idx[AW-1:0];   // stays below MEM_BYTES once size checked
  assign bit_set   = rdata[h[2:0]];

  clbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_accept),
    .waddr (AW'(byte_addr)),
    .wdata (byte_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      done         <= 1'b0;
      may_match    <= 1'b0;
      config_error <= 1'b0;
    end else begin
      done         <= 1'b0;
      may_match    <= 1'b0;
      config_error <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_accept) begin
            if (empty_filter) begin
              done <= 1'b1;
            end else if (oversized) begin
              done         <= 1'b1;
              config_error <= 1'b1;
            end else begin
              h       <= hash;
              delta   <= {hash[16:0], hash[HASH_W-1:17]};
              div_sh  <= hash;
              rem     <= '0;
              div_cnt <= '0;
              lb      <= lb_sat;
              busy    <= 1'b1;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_ge ? LINE_COUNT_W'(rem_sh - {1'b0, line_count})
                            : rem_sh[LINE_COUNT_W-1:0];
          div_sh  <= div_sh << 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(HASH_W - 1)) begin
            probe_idx <= '0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          if (probe_idx == probe_count) begin
            // every probed bit set (or no probes at all)
            done      <= 1'b1;
            may_match <= 1'b1;
            busy      <= 1'b0;
            state     <= S_IDLE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!bit_set) begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            h         <= h + delta;
            probe_idx <= probe_idx + 1'b1;
            state     <= S_RD;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result flags are only ever raised together with the strobe
  a_flags_with_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!may_match && !config_error))
    else $error("result flag raised without done");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(may_match && config_error))
    else $error("may_match and config_error both set");

  // Empty filter answers at once with no match and no error
  a_empty_fast: assert property (@(posedge clk) disable iff (rst)
    (q_accept && empty_filter) |=> (done && !may_match && !config_error && !busy))
    else $error("empty filter query not answered next cycle");

  // A sized query either errors at once or starts the division
  a_query_path: assert property (@(posedge clk) disable iff (rst)
    (q_accept && !empty_filter) |=> ((done && config_error) || (!done && busy)))
    else $error("query took wrong path");

  // Probing only happens while busy
  a_busy_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_RD || state == S_CHK) |-> busy)
    else $error("sequencer active while not busy");

endmodule

/* tb/sv/tb_cache_local_bloom_probe_unit.sv */
`timescale 1ns / 1ps

module tb_cache_local_bloom_probe_unit;
  import clbp_pkg::*;

  localparam int unsigned MEM_SIZE    = MEM_BYTES_DEFAULT;
  localparam int unsigned ITEM_TARGET = 1450;
  // The tail waits past the longest query (255 probes).
  localparam int unsigned TAIL_CYCLES = 600;
  // No register lives at the last index; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned MAX_REPORTS = 100;

  // One expected query answer, tagged with its hash for the mismatch line.
  typedef struct packed {
    logic [HASH_W-1:0] key;
    logic              may_match;
    logic              config_error;
  } query_answer_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  cmd;
  logic [ADDR_W-1:0]     byte_addr;
  logic [BYTE_W-1:0]     byte_value;
  logic [HASH_W-1:0]     hash;
  logic                  done;
  logic                  may_match;
  logic                  config_error;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cache_local_bloom_probe_unit dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the block: registers at reset values, filter bytes plus a
  // map of which ones were ever written (queries may only read written bytes).
  logic [LINE_COUNT_W-1:0] shadow_lines   = '0;
  logic [LB_LOG2_W-1:0]    shadow_lb_log2 = LB_LOG2_RESET;
  logic [PROBE_W-1:0]      shadow_probes  = PROBE_RESET;
  logic [BYTE_W-1:0]       shadow_filter [MEM_SIZE];
  bit                      byte_written  [MEM_SIZE];

  query_answer_t pending_answers [$];
  int unsigned   hot_lines [$];     // fully written lines of the current geometry
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  bit            no_gaps = 1'b0;

  // Line size in bytes; codes above 6 saturate to 64-byte lines.
  function automatic int unsigned line_bytes_now();
    return 1 << ((shadow_lb_log2 > LB_LOG2_MAX) ? LB_LOG2_MAX : shadow_lb_log2);
  endfunction

  // Expected answer of one query against the shadow state. Also flags whether
  // the probe walk would touch a byte that was never written.
  function automatic query_answer_t predict_answer(input logic [HASH_W-1:0] key,
                                                   output bit reads_unwritten);
    query_answer_t     ans;
    logic [HASH_W-1:0] run;
    logic [HASH_W-1:0] step;
    longint unsigned   filter_size;
    int unsigned       line_bits;
    int unsigned       base;
    int unsigned       bitpos;
    int unsigned       n;
    reads_unwritten  = 1'b0;
    ans              = '0;
    ans.key          = key;
    filter_size = 64'(shadow_lines) * line_bytes_now();
    if (shadow_lines == 0)
      return ans;
    if (filter_size > MEM_SIZE) begin
      ans.config_error = 1'b1;
      return ans;
    end
    line_bits = line_bytes_now() * 8;
    base      = (key % 32'(shadow_lines)) * line_bits;
    run       = key;
    step      = {key[16:0], key[31:17]};   // rotate left by 15
    ans.may_match = 1'b1;
    // walk stops at the first clear bit, as the block's reads do
    for (n = 0; n < shadow_probes && ans.may_match; n++) begin
      bitpos = base + (run & (line_bits - 1));
      if (!byte_written[bitpos >> 3])
        reads_unwritten = 1'b1;
      if (!shadow_filter[bitpos >> 3][bitpos[2:0]])
        ans.may_match = 1'b0;
      run = run + step;
    end
    return ans;
  endfunction

  // Hash whose line index (hash mod line count) is the given line.
  function automatic logic [HASH_W-1:0] hash_on_line(input int unsigned line);
    longint unsigned kmax;
    longint unsigned k;
    int unsigned     roll;
    kmax = (64'hFFFF_FFFF - line) / shadow_lines;
    roll = $urandom_range(9);
    if (roll == 0)
      k = 0;
    else if (roll == 1)
      k = kmax;
    else
      k = $urandom_range(32'(kmax), 0);
    return HASH_W'(k * shadow_lines + line);
  endfunction

  // Mostly-set filter bytes, so probe walks run deep before a clear bit.
  function automatic logic [BYTE_W-1:0] dense_byte();
    if ($urandom_range(3) == 0)
      return 8'hFF;
    return 8'($urandom() | $urandom());
  endfunction

  // Sender idle time: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps)
      return 0;
    roll = $urandom_range(99);
    if (roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(3, 1);
    if (roll < 98)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Result checker: every done strobe is one transfer that the receiver
  // cannot refuse; it must match the oldest query still waiting.
  always @(posedge clk) begin : check_results
    query_answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (may_match !== want.may_match)
          report_mismatch($sformatf("hash %08h: may_match %b, expected %b",
                                    want.key, may_match, want.may_match));
        if (config_error !== want.config_error)
          report_mismatch($sformatf("hash %08h: config_error %b, expected %b",
                                    want.key, config_error, want.config_error));
      end
    end
  end

  // One item transfer. Inputs move at the falling edge; the transfer happens
  // at the first rising edge with busy low, and only then is it predicted.
  task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] value,
                           input logic [HASH_W-1:0] key);
    int unsigned gap;
    bit          unwritten;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    cmd        <= op;
    byte_addr  <= addr;
    byte_value <= value;
    hash       <= key;
    do @(posedge clk); while (busy);
    items_sent++;
    if (op == CMD_QUERY) begin
      pending_answers.insert(pending_answers.size(), predict_answer(key, unwritten));
    end else begin
      shadow_filter[addr] = value;
      byte_written[addr]  = 1'b1;
    end
  endtask

  task automatic write_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    send_item(CMD_WRITE, addr, value, $urandom());
  endtask

  task automatic query(input logic [HASH_W-1:0] key);
    send_item(CMD_QUERY, $urandom(), $urandom(), key);
  endtask

  // Stop sending and wait until every query has answered and the block is free.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Register write; callers make sure the block is idle first.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_COUNT:      shadow_lines   = data[LINE_COUNT_W-1:0];
      REG_LINE_BYTES_LOG2: shadow_lb_log2 = data[LB_LOG2_W-1:0];
      REG_PROBE_COUNT:     shadow_probes  = data[PROBE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned lines, input int unsigned lb_code,
                              input int unsigned probes);
    drain_results();
    write_reg(REG_LINE_COUNT, CFG_DATA_W'(lines));
    write_reg(REG_LINE_BYTES_LOG2, CFG_DATA_W'(lb_code));
    write_reg(REG_PROBE_COUNT, CFG_DATA_W'(probes));
    hot_lines.delete();
  endtask

  task automatic fill_line(input int unsigned line, input bit all_ones);
    int unsigned nbytes;
    int unsigned b;
    nbytes = line_bytes_now();
    for (b = 0; b < nbytes; b++)
      write_byte(ADDR_W'(line * nbytes + b), all_ones ? 8'hFF : dense_byte());
    hot_lines.insert(hot_lines.size(), line);
  endtask

  // Reset values: empty filter first, then 64-byte lines and 6 probes with
  // only the line count written.
  task automatic test_reset_state();
    int unsigned i;
    query(32'h0000_0000);
    query(32'hFFFF_FFFF);
    query($urandom());
    drain_results();
    write_reg(REG_LINE_COUNT, CFG_DATA_W'(1));
    hot_lines.delete();
    fill_line(0, 1'b0);
    for (i = 0; i < 4; i++)
      query($urandom());
  endtask

  // Register extremes and the special cases of the query path.
  task automatic test_config_limits();
    // largest count the register holds: oversized
    set_geometry(17'h1FFFF, 6, 6);
    query(32'h0000_0000);
    query(32'hFFFF_FFFF);
    // one line past memory, then exactly full
    set_geometry(1025, 6, 6);
    query($urandom());
    set_geometry(1024, 6, 255);
    fill_line(1023, 1'b1);                 // ends at the top byte, all ones
    query(32'hFFFF_FFFF);                  // 255 probes, every bit set
    // line size code 7 saturates to 64-byte lines
    drain_results();
    write_reg(REG_LINE_BYTES_LOG2, CFG_DATA_W'(7));
    query(hash_on_line(1023));
    // zero probes: nothing tested, answer is a match
    drain_results();
    write_reg(REG_PROBE_COUNT, CFG_DATA_W'(0));
    query(32'h0000_0000);
    // write to the unused index must leave every register alone
    drain_results();
    write_reg(REG_UNUSED, 17'h1FFFF);
    query(32'hFFFF_FFFF);
    // one-byte lines filling all of memory
    set_geometry(65536, 0, 1);
    write_byte(16'h0000, 8'h00);
    query(32'h0000_0000);                  // first bit clear
    query(32'hFFFF_FFFF);                  // top byte, all ones
    set_geometry(65537, 0, 1);
    query(32'hFFFF_FFFF);
  endtask

  task automatic random_item();
    int unsigned       roll;
    int unsigned       line;
    int unsigned       nbytes;
    logic [HASH_W-1:0] key;
    bit                unwritten;
    roll   = $urandom_range(99);
    nbytes = line_bytes_now();
    if (roll < 20) begin
      if (roll < 10 && hot_lines.size() != 0) begin
        line = hot_lines[$urandom_range(hot_lines.size() - 1)];
        write_byte(ADDR_W'(line * nbytes + $urandom_range(nbytes - 1)),
                   $urandom_range(1) ? 8'hFF : 8'($urandom()));
      end else begin
        write_byte($urandom(), $urandom());
      end
    end else begin
      key = $urandom();
      if (roll < 90 && hot_lines.size() != 0)
        key = hash_on_line(hot_lines[$urandom_range(hot_lines.size() - 1)]);
      void'(predict_answer(key, unwritten));
      // a stray hash landing on unwritten bytes is steered onto a filled line
      if (unwritten)
        key = hash_on_line(hot_lines[$urandom_range(hot_lines.size() - 1)]);
      query(key);
    end
    if ($urandom_range(49) == 0)
      drain_results();
  endtask

  // Phases of random geometry, each with a few filled lines and a mix of
  // targeted queries, stray queries and writes.
  task automatic test_random_traffic();
    int unsigned lb_code;
    int unsigned cap;
    int unsigned lines;
    int unsigned probes;
    int unsigned fills;
    int unsigned roll;
    int unsigned i;
    while (items_sent < ITEM_TARGET) begin
      lb_code = $urandom_range(7);
      cap     = MEM_SIZE >> ((lb_code > 6) ? 6 : lb_code);
      roll    = $urandom_range(19);
      if (roll == 0)
        lines = 0;
      else if (roll < 3)
        lines = $urandom_range(131071, cap + 1);
      else if (roll < 5)
        lines = cap;
      else if (roll < 10)
        lines = $urandom_range(8, 1);
      else
        lines = $urandom_range(cap, 1);
      roll = $urandom_range(9);
      if (roll == 0)
        probes = 0;
      else if (roll == 1)
        probes = 255;
      else if (roll < 4)
        probes = $urandom_range(255);
      else
        probes = $urandom_range(16, 1);
      set_geometry(lines, lb_code, probes);
      no_gaps = ($urandom_range(3) == 0);
      if (lines != 0 && lines <= cap) begin
        fills = 1 + $urandom_range(96 / line_bytes_now());
        if (fills > lines)
          fills = lines;
        fill_line(lines - 1, $urandom_range(2) == 0);
        for (i = 1; i < fills; i++)
          fill_line($urandom_range(lines - 1), $urandom_range(2) == 0);
      end
      repeat ($urandom_range(160, 80))
        random_item();
    end
    no_gaps = 1'b0;
  endtask

  // Slowest correct run: about 2000 transfers, each the longest query plus the
  // longest sender gap, is near 24 ms; allow eight times that.
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_WRITE;
    byte_addr  = '0;
    byte_value = '0;
    hash       = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_LINE_COUNT;
    cfg_wdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_config_limits();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
